// ===== rtl/kct_pkg.sv =====
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types, constants and helpers of the k-mer counting table.
// ----------------------------------------------------------------------------
package kct_pkg;

	localparam int BASES_PER_WORD    = 32;
	localparam int WORD_W            = 64;
	localparam int KMER_BASES_DEF    = 256;
	localparam int KEY_WORDS_DEF     = 8;
	localparam int TABLE_ENTRIES_DEF = 16384;

	localparam int          PROBE_W     = 15;
	localparam logic [14:0] PROBE_RST   = 15'd64;
	localparam int          DISTINCT_W  = 15;
	localparam logic [14:0] DISTINCT_MAX = 15'h7FFF;

	localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
	localparam int          HASH_SHIFT = 29;

	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_T = 8'h54;

	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_EOS  = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HSTART,
		S_HASH,
		S_MRD,
		S_MCHK,
		S_KRD,
		S_KCMP,
		S_KWR,
		S_MWR,
		S_RDWAIT,
		S_RDCHK,
		S_RDKWAIT,
		S_RDKEY,
		S_DONE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_XOR,
		H_M0,
		H_M1,
		H_M2,
		H_ADD,
		H_MIX,
		H_MOD
	} hash_state_t;

	typedef struct packed {
		logic       push;
		logic       clear;
		logic [1:0] code;
	} win_ctrl_t;

	function automatic logic [1:0] base_code(input logic [7:0] c);
		logic [1:0] r;
		r = 2'd0;
		if (c == CHAR_C) r = 2'd1;
		if (c == CHAR_G) r = 2'd2;
		if (c == CHAR_T) r = 2'd3;
		return r;
	endfunction

endpackage

// ===== rtl/kmer_counting_table_unit.sv =====
// ----------------------------------------------------------------------------
// kmer_counting_table_unit
// K-mer counting hash table with sliding base window and linear probing.
// ----------------------------------------------------------------------------
// A push that leaves the window full is hashed on the shared multiplier; then
// each probed slot takes a meta read and check plus a read and compare of each
// key word up to the first mismatch, and an insert writes the key words, then meta.
// Other pushes and end of sequence are taken without leaving S_IDLE.
// One item at a time. After reset the table metadata RAM is swept
// before the first item is taken; config is taken anytime.
// ----------------------------------------------------------------------------
module kmer_counting_table_unit
	import kct_pkg::*;
#(
	parameter int KMER_BASES    = KMER_BASES_DEF,
	parameter int KEY_WORDS     = KEY_WORDS_DEF,
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [14:0]   cfg_data,     // probe_limit
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,      // base_char, entry_index, word_select, pad
	input  logic [1:0]    s_tuser,      // req_type
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [143:0]  m_tdata,      // key_word, first_position,
	                                    // occurrence_count, distinct_count, pad
	output logic [2:0]    m_tuser       // is_new_kmer, table_full, entry_valid
);

	localparam int AW  = $clog2(TABLE_ENTRIES);
	localparam int KWB = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam int LW  = (AW + 1 > PROBE_W) ? AW + 1 : PROBE_W;
	localparam int KAW = AW + KWB;
	localparam int MW  = 65;

	ctrl_state_t state_q, state_n;

	logic [14:0]    probe_limit_q;
	logic [AW-1:0]  slot_q, clr_q, slot_next;
	logic [KWB-1:0] w_q;
	logic [LW-1:0]  probe_q, limit_q, limit_new, cfg_ext, total_q;
	logic [31:0]    start_q, meta_pos_q, meta_cnt_q, cnt_sat;
	logic           ins_q, inrange_q, wsok_q;
	logic [2:0]     res_flags_q;
	logic [63:0]    res_key_q;
	logic [31:0]    res_pos_q, res_cnt_q;
	logic           m_tvalid_q;
	logic [143:0]   m_tdata_q;
	logic [2:0]     m_tuser_q;
	logic [14:0]    distinct;

	logic [1:0]  req_type;
	logic [7:0]  base_char;
	logic [13:0] entry_index;
	logic [2:0]  word_select;
	logic        accept, out_free, out_load, last_w, key_match, probes_done;

	win_ctrl_t                   win_ctrl;
	logic [KEY_WORDS*WORD_W-1:0] window;
	logic                        fills_now;
	logic [31:0]                 position;
	logic [63:0]                 win_word;

	logic                        hash_start, hash_done;
	logic [AW-1:0]               hash_slot;

	logic          meta_we;
	logic [AW-1:0] meta_waddr;
	logic [MW-1:0] meta_wdata, meta_rdata;
	logic          key_we;
	logic [63:0]   key_rdata;

	assign req_type    = s_tuser;
	assign base_char   = s_tdata[7:0];
	assign entry_index = s_tdata[21:8];
	assign word_select = s_tdata[24:22];

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign out_load  = (state_q == S_DONE) && out_free;

	assign win_word    = window[w_q*WORD_W +: WORD_W];
	assign last_w      = w_q == KWB'(KEY_WORDS - 1);
	assign key_match   = key_rdata == win_word;
	assign probes_done = (probe_q + 1'b1) == limit_q;
	assign slot_next   = (slot_q == AW'(TABLE_ENTRIES - 1)) ? '0 : slot_q + 1'b1;
	assign cnt_sat     = (meta_cnt_q == 32'hFFFF_FFFF) ? meta_cnt_q : meta_cnt_q + 32'd1;

	assign cfg_ext   = LW'(probe_limit_q);
	assign limit_new = (probe_limit_q == '0) ? LW'(1) :
	                   (cfg_ext > LW'(TABLE_ENTRIES)) ? LW'(TABLE_ENTRIES) : cfg_ext;
	assign distinct  = (total_q > LW'(DISTINCT_MAX)) ? DISTINCT_MAX : total_q[14:0];

	kct_window #(
		.KMER_BASES(KMER_BASES),
		.KEY_WORDS (KEY_WORDS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (win_ctrl),
		.window   (window),
		.fills_now(fills_now),
		.position (position)
	);

	kct_hash #(
		.KEY_WORDS    (KEY_WORDS),
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   (window),
		.done  (hash_done),
		.slot  (hash_slot)
	);

	// valid, first position, count per slot
	kct_ram #(
		.WIDTH(MW),
		.DEPTH(TABLE_ENTRIES)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wdata),
		.raddr(slot_q),
		.rdata(meta_rdata)
	);

	kct_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_ENTRIES << KWB)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(KAW'({slot_q, w_q})),
		.wdata(win_word),
		.raddr(KAW'({slot_q, w_q})),
		.rdata(key_rdata)
	);

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == AW'(TABLE_ENTRIES - 1)) state_n = S_IDLE;
			S_IDLE: begin
				if (s_tvalid) begin
					case (req_type)
						REQ_PUSH: if (fills_now) state_n = S_HSTART;
						REQ_READ: state_n = S_RDWAIT;
						default:  state_n = S_IDLE;
					endcase
				end
			end
			S_HSTART:  state_n = S_HASH;
			S_HASH:    if (hash_done) state_n = S_MRD;
			S_MRD:     state_n = S_MCHK;
			S_MCHK:    state_n = meta_rdata[MW-1] ? S_KRD : S_KWR;
			S_KRD:     state_n = S_KCMP;
			S_KCMP: begin
				if (!key_match) state_n = probes_done ? S_DONE : S_MRD;
				else            state_n = last_w ? S_MWR : S_KRD;
			end
			S_KWR:     if (last_w) state_n = S_MWR;
			S_MWR:     state_n = S_DONE;
			S_RDWAIT:  state_n = S_RDCHK;
			S_RDCHK:   state_n = (inrange_q && meta_rdata[MW-1] && wsok_q) ? S_RDKWAIT : S_DONE;
			S_RDKWAIT: state_n = S_RDKEY;
			S_RDKEY:   state_n = S_DONE;
			S_DONE:    if (out_free) state_n = S_IDLE;
			default:   state_n = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = state_q == S_IDLE;
		hash_start    = state_q == S_HSTART;
		win_ctrl.push  = accept && (req_type == REQ_PUSH);
		win_ctrl.clear = accept && (req_type == REQ_EOS);
		win_ctrl.code  = base_code(base_char);
		key_we        = state_q == S_KWR;
		meta_we       = 1'b0;
		meta_waddr    = slot_q;
		meta_wdata    = '0;
		case (state_q)
			S_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q;
			end
			S_MWR: begin
				meta_we    = 1'b1;
				meta_wdata = ins_q ? {1'b1, start_q, 32'd1} : {1'b1, meta_pos_q, cnt_sat};
			end
			default: meta_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			probe_limit_q <= PROBE_RST;
			clr_q         <= '0;
			total_q       <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				probe_limit_q <= cfg_data;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_MWR && ins_q) begin
				total_q <= total_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {1'b0, distinct, res_cnt_q, res_pos_q, res_key_q};
			m_tuser_q <= res_flags_q;
		end
		case (state_q)
			S_IDLE: begin
				start_q   <= position - 32'(KMER_BASES - 1);
				limit_q   <= limit_new;
				probe_q   <= '0;
				slot_q    <= AW'(entry_index);
				inrange_q <= 32'(entry_index) < 32'(TABLE_ENTRIES);
				wsok_q    <= {1'b0, word_select} < 4'(KEY_WORDS);
				w_q       <= KWB'(word_select);
				res_flags_q <= '0;
				res_key_q   <= '0;
				res_pos_q   <= '0;
				res_cnt_q   <= '0;
			end
			S_HASH: slot_q <= hash_slot;
			S_MCHK: begin
				meta_pos_q <= meta_rdata[63:32];
				meta_cnt_q <= meta_rdata[31:0];
				ins_q      <= !meta_rdata[MW-1];
				w_q        <= '0;
			end
			S_KCMP: begin
				if (!key_match) begin
					probe_q <= probe_q + 1'b1;
					slot_q  <= slot_next;
					if (probes_done) begin
						res_flags_q <= 3'b010;
						res_pos_q   <= start_q;
					end
				end else if (!last_w) begin
					w_q <= w_q + 1'b1;
				end
			end
			S_KWR: if (!last_w) w_q <= w_q + 1'b1;
			S_MWR: begin
				res_flags_q <= {2'b00, ins_q};
				res_pos_q   <= ins_q ? start_q : meta_pos_q;
				res_cnt_q   <= ins_q ? 32'd1 : cnt_sat;
			end
			S_RDCHK: begin
				if (inrange_q && meta_rdata[MW-1]) begin
					res_flags_q <= 3'b100;
					res_pos_q   <= meta_rdata[63:32];
					res_cnt_q   <= meta_rdata[31:0];
				end
			end
			S_RDKEY: res_key_q <= key_rdata;
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MRD) |-> (probe_q < limit_q))
		else $error("probe count reached limit while probing");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= LW'(TABLE_ENTRIES))
		else $error("distinct total exceeds table size");

	a_hash_done: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> (state_q == S_HASH))
		else $error("hash finished outside hash wait");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_free) |=> (state_q == S_DONE))
		else $error("result dropped while output busy");

endmodule

// ===== rtl/kct_ram.sv =====
// ----------------------------------------------------------------------------
// kct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kct_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/kct_window.sv =====
// ----------------------------------------------------------------------------
// kct_window
// Sliding 2-bit packed base window, fill count and running base position.
// ----------------------------------------------------------------------------
module kct_window
	import kct_pkg::*;
#(
	parameter int KMER_BASES = KMER_BASES_DEF,
	parameter int KEY_WORDS  = KEY_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  win_ctrl_t                   ctrl,
	output logic [KEY_WORDS*WORD_W-1:0] window,
	output logic                        fills_now,
	output logic [31:0]                 position
);

	localparam int WIN_W   = KEY_WORDS * WORD_W;
	localparam int TOP_BIT = 2 * (KMER_BASES - 1);
	localparam bit HAS_TOP = (TOP_BIT + 2) <= WIN_W;
	localparam int TOP_IDX = HAS_TOP ? TOP_BIT : 0;
	localparam int FW      = $clog2(KMER_BASES + 1);

	logic [WIN_W-1:0] win_q, shifted;
	logic [FW-1:0]    fill_q;
	logic [31:0]      pos_q;

	always_comb begin
		shifted = win_q >> 2;
		shifted[TOP_IDX +: 2] = shifted[TOP_IDX +: 2] | (HAS_TOP ? ctrl.code : 2'b00);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
			pos_q  <= '0;
		end else if (ctrl.clear) begin
			win_q  <= '0;
			fill_q <= '0;
		end else if (ctrl.push) begin
			win_q <= shifted;
			pos_q <= pos_q + 32'd1;
			if (fill_q < FW'(KMER_BASES)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// the push now accepted leaves the window full
	assign fills_now = fill_q >= FW'(KMER_BASES - 1);
	assign window    = win_q;
	assign position  = pos_q;

endmodule

// ===== rtl/kct_hash.sv =====
// ----------------------------------------------------------------------------
// kct_hash
// Key hash on one shared 32x32 multiplier; the slot is the low index bits of
// the upper hash word (table size is a power of two).
// ----------------------------------------------------------------------------
module kct_hash
	import kct_pkg::*;
#(
	parameter int KEY_WORDS     = KEY_WORDS_DEF,
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [KEY_WORDS*WORD_W-1:0]      key,
	output logic                             done,
	output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);

	localparam int AW  = $clog2(TABLE_ENTRIES);
	localparam int KWB = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

	hash_state_t    state_q;
	logic [63:0]    h_q, x_q, acc_q, mul_q;
	logic [31:0]    op_a, op_b;
	logic [KWB-1:0] rnd_q;
	logic [63:0]    mixed;
	logic           done_q;

	always_comb begin
		case (state_q)
			H_M0:    begin op_a = x_q[31:0];  op_b = HASH_MULT[31:0];  end
			H_M1:    begin op_a = x_q[63:32]; op_b = HASH_MULT[31:0];  end
			H_M2:    begin op_a = x_q[31:0];  op_b = HASH_MULT[63:32]; end
			default: begin op_a = '0;         op_b = '0;               end
		endcase
	end

	assign mixed = acc_q ^ (acc_q >> HASH_SHIFT);

	always_ff @(posedge clk) begin
		mul_q <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
			rnd_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						state_q <= H_XOR;
						rnd_q   <= '0;
						h_q     <= '0;
					end
				end
				H_XOR: begin
					x_q     <= h_q ^ key[rnd_q*WORD_W +: WORD_W];
					state_q <= H_M0;
				end
				H_M0: state_q <= H_M1;
				H_M1: begin
					acc_q   <= mul_q;
					state_q <= H_M2;
				end
				H_M2: begin
					acc_q   <= acc_q + {mul_q[31:0], 32'd0};
					state_q <= H_ADD;
				end
				H_ADD: begin
					acc_q   <= acc_q + {mul_q[31:0], 32'd0};
					state_q <= H_MIX;
				end
				H_MIX: begin
					h_q <= mixed;
					if (rnd_q == KWB'(KEY_WORDS - 1)) begin
						state_q <= H_IDLE;
						done_q  <= 1'b1;
					end else begin
						rnd_q   <= rnd_q + 1'b1;
						state_q <= H_XOR;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done = done_q;
	// modulo by the table size: mask of the upper hash word
	assign slot = h_q[32 +: AW];

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-mer counting table. It drives push, end of
// sequence, read and ignored requests over the input stream, with random
// gaps and stalls, and a long receiver hold-off. The probe limit is set to
// several values, the extremes among them. A scoreboard keeps its own
// window and hash table, predicts each result and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module tb_top
	import kct_pkg::*;
();

	localparam int N_SLOTS   = 16384;
	localparam int WIN_BASES = 256;
	localparam int IDLE_LIMIT = 60000;

	typedef struct {
		bit        is_new;
		bit        full;
		bit        valid;
		bit [63:0] key_word;
		bit [31:0] first_pos;
		bit [31:0] count;
		bit [14:0] distinct;
	} kmer_result_t;

	class kmer_scoreboard;
		bit [511:0]   window;
		int unsigned  fill;
		bit [31:0]    position;
		bit           slot_used [N_SLOTS];
		bit [511:0]   slot_key  [N_SLOTS];
		bit [31:0]    slot_pos  [N_SLOTS];
		bit [31:0]    slot_cnt  [N_SLOTS];
		int unsigned  stored;
		int unsigned  probe_limit = 64;
		kmer_result_t expected_q [$];
		int           used_slots [$];
		int           errors;
		int           n_new, n_hit, n_full, n_read;

		function bit [13:0] slot_of(bit [511:0] k);
			bit [63:0] h;
			h = 64'd0;
			for (int w = 0; w < 8; w++) begin
				h = (h ^ k[64*w +: 64]) * HASH_MULT;
				h ^= h >> HASH_SHIFT;
			end
			return h[45:32];
		endfunction

		function bit [1:0] code_of(bit [7:0] c);
			case (c)
				CHAR_C:  return 2'd1;
				CHAR_G:  return 2'd2;
				CHAR_T:  return 2'd3;
				default: return 2'd0;
			endcase
		endfunction

		function bit [14:0] distinct_now();
			return (stored > 32767) ? 15'h7FFF : stored[14:0];
		endfunction

		// would the push of c land on a slot held by a different k-mer
		function bit hits_other(bit [7:0] c);
			bit [511:0] k;
			bit [13:0]  s;
			if (fill < WIN_BASES - 1)
				return 0;
			k = {code_of(c), window[511:2]};
			s = slot_of(k);
			return slot_used[s] && slot_key[s] != k;
		endfunction

		function void note_item(bit [1:0] req, bit [7:0] ch, bit [13:0] idx, bit [2:0] ws);
			kmer_result_t r;
			bit [31:0]    start;
			int unsigned  lim;
			bit [13:0]    s;
			bit           done;
			r = '{default: 0};
			case (req)
				REQ_PUSH: begin
					start = position - (WIN_BASES - 1);
					window = {code_of(ch), window[511:2]};
					position++;
					if (fill < WIN_BASES)
						fill++;
					if (fill < WIN_BASES)
						return;
					lim = (probe_limit == 0) ? 1 : (probe_limit > N_SLOTS ? N_SLOTS : probe_limit);
					s = slot_of(window);
					done = 0;
					for (int i = 0; i < lim && !done; i++) begin
						if (!slot_used[s]) begin
							slot_used[s] = 1;
							slot_key[s] = window;
							slot_pos[s] = start;
							slot_cnt[s] = 1;
							stored++;
							used_slots = {used_slots, int'(s)};
							r.is_new = 1;
							r.first_pos = start;
							r.count = 1;
							n_new++;
							done = 1;
						end else if (slot_key[s] == window) begin
							if (slot_cnt[s] != 32'hFFFF_FFFF)
								slot_cnt[s]++;
							r.first_pos = slot_pos[s];
							r.count = slot_cnt[s];
							n_hit++;
							done = 1;
						end else begin
							s++;
						end
					end
					if (!done) begin
						r.full = 1;
						r.first_pos = start;
						n_full++;
					end
					r.distinct = distinct_now();
					expected_q = {expected_q, r};
				end
				REQ_EOS: begin
					window = '0;
					fill = 0;
				end
				REQ_READ: begin
					r.distinct = distinct_now();
					if (slot_used[idx]) begin
						r.valid = 1;
						r.key_word = slot_key[idx][64*ws +: 64];
						r.first_pos = slot_pos[idx];
						r.count = slot_cnt[idx];
					end
					n_read++;
					expected_q = {expected_q, r};
				end
				default: ;
			endcase
		endfunction

		task report(string what, bit [63:0] got, bit [63:0] want);
			errors++;
			if (errors <= 40)
				$display("mismatch %s: got %h expected %h", what, got, want);
		endtask

		task check_result(bit [2:0] user, bit [143:0] data);
			kmer_result_t e;
			if (expected_q.size() == 0) begin
				report("unexpected result", data[63:0], 64'd0);
				return;
			end
			e = expected_q.pop_front();
			if (user[0] != e.is_new)
				report("is_new_kmer", 64'(user[0]), 64'(e.is_new));
			if (user[1] != e.full)
				report("table_full", 64'(user[1]), 64'(e.full));
			if (user[2] != e.valid)
				report("entry_valid", 64'(user[2]), 64'(e.valid));
			if (data[63:0] != e.key_word)
				report("key_word", data[63:0], e.key_word);
			if (data[95:64] != e.first_pos)
				report("first_position", 64'(data[95:64]), 64'(e.first_pos));
			if (data[127:96] != e.count)
				report("occurrence_count", 64'(data[127:96]), 64'(e.count));
			if (data[142:128] != e.distinct)
				report("distinct_count", 64'(data[142:128]), 64'(e.distinct));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [14:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic [2:0]   m_tuser;

	kmer_scoreboard sb = new();
	int           hold_cycles;
	bit           quiet;
	int           idle_cnt;
	bit [7:0]     genome [512];
	bit [7:0]     motif [8];
	int           motif_len;
	int           items_sent;

	kmer_counting_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver side: random stalls, occasional long ones, and forced hold-off
	initial begin
		m_tready = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 0;
			end else if (quiet) begin
				m_tready <= 1;
			end else if ($urandom_range(0, 199) == 0) begin
				hold_cycles = $urandom_range(20, 120);
				m_tready <= 0;
			end else begin
				m_tready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task send_item(bit [1:0] req, bit [7:0] ch, bit [13:0] idx, bit [2:0] ws);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= req;
		s_tdata <= {7'd0, ws, idx, ch};
		do @(posedge clk); while (!s_tready);
		sb.note_item(req, ch, idx, ws);
		items_sent++;
	endtask

	task wait_drained();
		s_tvalid <= 0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task write_probe(bit [14:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.probe_limit = v;
	endtask

	function bit [7:0] acgt();
		bit [7:0] set [4];
		set = '{"A", "C", "G", "T"};
		return set[$urandom_range(0, 3)];
	endfunction

	function bit [7:0] seq_char(int mode, int i);
		case (mode)
			0:       return acgt();
			1:       return motif[i % motif_len];
			default: return genome[i % 512];
		endcase
	endfunction

	task send_read();
		bit [13:0] idx;
		if (sb.used_slots.size() > 0 && $urandom_range(0, 1))
			idx = 14'(sb.used_slots[$urandom_range(0, sb.used_slots.size() - 1)]);
		else
			idx = 14'($urandom_range(0, N_SLOTS - 1));
		send_item(REQ_READ, 8'($urandom_range(0, 255)), idx, 3'($urandom_range(0, 7)));
	endtask

	// a fresh run empties and refills the window, otherwise it carries on
	task run_sequence(int mode, int extra, bit steer, bit squeeze, bit fresh);
		bit [7:0] c;
		int       r;
		motif_len = $urandom_range(1, 8);
		foreach (motif[i]) motif[i] = acgt();
		if (fresh) begin
			send_item(REQ_EOS, 8'($urandom_range(0, 255)), 14'($urandom), 3'($urandom));
			for (int i = 0; i < WIN_BASES - 1; i++)
				send_item(REQ_PUSH, seq_char(mode, i), 14'($urandom), 3'($urandom));
		end
		for (int i = 0; i < extra; i++) begin
			if (squeeze && i == extra / 2)
				hold_cycles = 3000;
			r = $urandom_range(0, 99);
			if (r < 72) begin
				c = seq_char(mode, WIN_BASES - 1 + i);
				if (steer)
					for (int t = 0; t < 4; t++)
						if (sb.hits_other(8'("ACGT" >> (8 * t))))
							c = 8'("ACGT" >> (8 * t));
				send_item(REQ_PUSH, c, 14'($urandom), 3'($urandom));
			end else if (r < 88) begin
				send_read();
			end else if (r < 93) begin
				send_item(2'd3, 8'($urandom_range(0, 255)), 14'($urandom), 3'($urandom));
			end else if (r < 98) begin
				send_item(REQ_PUSH, 8'($urandom_range(0, 255)), 14'($urandom),
					3'($urandom));
			end else begin
				send_item(REQ_EOS, 8'($urandom_range(0, 255)), 14'($urandom), 3'($urandom));
			end
		end
	endtask

	initial begin
		bit [7:0]  odd [9];
		bit [14:0] probes [6];
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		hold_cycles = 0;
		quiet = 0;
		idle_cnt = 0;
		items_sent = 0;
		foreach (genome[i]) genome[i] = acgt();
		odd = '{"A", "C", "G", "T", "a", "c", "N", 8'h00, 8'hFF};
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: empty reads at both index ends, ignored type, lower case
		// and other characters as A, then each base once the window is full
		write_probe(PROBE_RST);
		send_item(REQ_READ, 8'h00, 14'd0, 3'd0);
		send_item(REQ_READ, 8'hFF, 14'h3FFF, 3'd7);
		send_item(2'd3, 8'hFF, 14'h3FFF, 3'd7);
		send_item(REQ_EOS, 8'h00, 14'd0, 3'd0);
		for (int i = 0; i < WIN_BASES - 1; i++)
			send_item(REQ_PUSH, odd[i % 9], 14'd0, 3'd0);
		send_item(REQ_PUSH, "A", 14'd0, 3'd0);
		send_item(REQ_PUSH, "C", 14'd0, 3'd0);
		send_item(REQ_PUSH, "G", 14'd0, 3'd0);
		send_item(REQ_PUSH, "T", 14'd0, 3'd0);
		send_item(REQ_READ, 8'h00, 14'(sb.used_slots[0]), 3'd0);
		send_item(REQ_READ, 8'h00, 14'(sb.used_slots[3]), 3'd7);
		// same k-mer again after an end of sequence: count goes up
		send_item(REQ_EOS, 8'h00, 14'd0, 3'd0);
		for (int i = 0; i < WIN_BASES - 1; i++)
			send_item(REQ_PUSH, odd[i % 9], 14'd0, 3'd0);
		send_item(REQ_PUSH, "A", 14'd0, 3'd0);
		wait_drained();

		probes = '{15'd1, 15'd0, 15'h7FFF, 15'd16384, 15'd2, 15'd0};
		probes[5] = 15'($urandom_range(3, 300));
		for (int k = 0; k < 6; k++) begin
			write_probe(probes[k]);
			quiet = (k == 3);
			run_sequence(k % 3, 145, probes[k] <= 2, k == 2, k % 3 == 0);
			quiet = 0;
			wait_drained();
		end

		repeat (100) @(posedge clk);
		$display("covered %0d items: %0d new k-mers, %0d repeats, %0d table full, %0d reads",
			items_sent, sb.n_new, sb.n_hit, sb.n_full, sb.n_read);
		$display("probe limits 64, 1, 0, 32767, 16384, 2 and %0d; %0d mismatches",
			probes[5], sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
